>>> rtl/fct_pkg.sv
package fct_pkg;

    // Table geometry.
    localparam int SECTOR_BYTES  = 512;
    localparam int TABLE_SECTORS = 9;
    localparam int TABLE_BYTES   = SECTOR_BYTES * TABLE_SECTORS;

    // The table is split into an even-byte bank and an odd-byte bank.
    localparam int BANK_ROWS = TABLE_BYTES / 2;
    localparam int ROW_W     = $clog2(BANK_ROWS);

    // Width of a byte index c + c/2 + 1 for any 12-bit cluster, and of the table size.
    localparam int TB_W  = $clog2(TABLE_BYTES + 1);
    localparam int IDX_W = (TB_W > 13) ? TB_W : 13;

    localparam logic [11:0] CHAIN_END     = 12'hFF8;
    localparam logic [11:0] FIRST_CLUSTER = 12'h002;
    localparam logic [11:0] FREE_ENTRY    = 12'h000;
    localparam logic [11:0] LIMIT_RESET   = 12'd2848;

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_READ = 3'd1,
        OP_GET  = 3'd2,
        OP_SET  = 3'd3,
        OP_FIND = 3'd4,
        OP_FREE = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [11:0] cluster;
        logic [11:0] value;
        logic [12:0] byte_addr;
        logic [7:0]  byte_data;
    } t_fct_in;

    typedef struct packed {
        logic [11:0] entry;
        logic [7:0]  byte_out;
        logic [11:0] freed_count;
        logic        status;
    } t_fct_out;

    // Entry held in the low byte and high byte of its byte pair.
    function automatic logic [11:0] fct_decode(input logic odd, input logic [7:0] lo,
                                               input logic [7:0] hi);
        return odd ? {hi, lo[7:4]} : {hi[3:0], lo};
    endfunction

    // New {high byte, low byte} after writing entry v into the pair.
    function automatic logic [15:0] fct_merge(input logic odd, input logic [7:0] lo,
                                              input logic [7:0] hi, input logic [11:0] v);
        return odd ? {v[11:4], v[3:0], lo[3:0]} : {hi[7:4], v[11:8], v[7:0]};
    endfunction

endpackage

>>> rtl/fct_ram.sv
module fct_ram #(
    parameter int DEPTH = 2304,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port: a cycle either writes or reads; the read data is registered and lands in the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fat12_cluster_table_engine.sv
// Find free scans one cluster a cycle; free chain does one read-modify-write of both
// table banks per link.
// One item is in work at a time; the next beat is taken in the cycle its result is shown.
// Reset is synchronous and active low; it clears the control state and sets the search
// limit to 2848. Table contents are not cleared and are undefined until loaded.
module fat12_cluster_table_engine
    import fct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_fct_in     i_item,
    output logic        o_done,
    output t_fct_out    o_result,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_data
);

    // Sequencer states. ISSUE starts a table access, DATA consumes its read data,
    // SCAN streams the free-entry search at one cluster per cycle.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DATA  = 4'b0100,
        S_SCAN  = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    t_fct_in     r_item, n_item;
    logic [11:0] r_cur, n_cur;
    logic [11:0] r_chk, n_chk;
    logic        r_chk_v, n_chk_v;
    logic        r_chk_lo_b1, n_chk_lo_b1;
    logic [11:0] r_freed, n_freed;
    logic [11:0] r_limit;
    logic        r_done, n_done;
    t_fct_out    r_res, n_res;

    // Bank ports. Bank 0 holds even table bytes, bank 1 holds odd table bytes.
    logic             b0_en, b0_we, b1_en, b1_we;
    logic [ROW_W-1:0] b0_addr, b1_addr;
    logic [7:0]       b0_wd, b1_wd, q0, q1;

    // Byte pair of the current cluster. The pair always straddles both banks:
    // bank 0 row is (idx+1)/2 and bank 1 row is idx/2; idx parity says which holds the low byte.
    logic [IDX_W-1:0] idx, idx_nx;
    logic             in_tab, lo_b1;
    logic [ROW_W-1:0] row_b0, row_b1;
    logic [7:0]       rd_lo, rd_hi;
    logic [11:0]      cur_entry, chk_entry;
    logic [15:0]      mrg_set, mrg_zero;
    logic             byte_ok;
    logic [ROW_W-1:0] byte_row;
    logic             chain_live, scan_live;

    assign idx        = IDX_W'(r_cur) + IDX_W'(r_cur >> 1);
    assign idx_nx     = idx + IDX_W'(1);
    assign in_tab     = idx_nx < IDX_W'(TABLE_BYTES);
    assign row_b0     = ROW_W'(idx_nx >> 1);
    assign row_b1     = ROW_W'(idx >> 1);
    assign lo_b1      = idx[0];
    assign rd_lo      = lo_b1 ? q1 : q0;
    assign rd_hi      = lo_b1 ? q0 : q1;
    assign cur_entry  = fct_decode(r_cur[0], rd_lo, rd_hi);
    assign chk_entry  = fct_decode(r_chk[0], r_chk_lo_b1 ? q1 : q0, r_chk_lo_b1 ? q0 : q1);
    assign mrg_set    = fct_merge(r_cur[0], rd_lo, rd_hi, r_item.value);
    assign mrg_zero   = fct_merge(r_cur[0], rd_lo, rd_hi, FREE_ENTRY);
    assign byte_ok    = IDX_W'(r_item.byte_addr) < IDX_W'(TABLE_BYTES);
    assign byte_row   = ROW_W'(r_item.byte_addr >> 1);
    assign chain_live = (r_cur >= FIRST_CLUSTER) && (r_cur < CHAIN_END);
    assign scan_live  = (r_cur < r_limit) && in_tab;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_cur       = r_cur;
        n_chk       = r_chk;
        n_chk_v     = r_chk_v;
        n_chk_lo_b1 = r_chk_lo_b1;
        n_freed     = r_freed;
        n_done      = 1'b0;
        n_res       = r_res;

        b0_en   = 1'b0;
        b0_we   = 1'b0;
        b0_addr = row_b0;
        b0_wd   = lo_b1 ? mrg_set[15:8] : mrg_set[7:0];
        b1_en   = 1'b0;
        b1_we   = 1'b0;
        b1_addr = row_b1;
        b1_wd   = lo_b1 ? mrg_set[7:0] : mrg_set[15:8];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_freed = '0;
                    n_chk_v = 1'b0;
                    if (i_item.opcode == OP_FIND) begin
                        n_cur   = FIRST_CLUSTER;
                        n_state = S_SCAN;
                    end else begin
                        n_cur   = i_item.cluster;
                        n_state = S_ISSUE;
                    end
                end
            end

            S_ISSUE: begin
                n_res = '0;
                unique case (r_item.opcode)
                    OP_LOAD: begin
                        if (byte_ok) begin
                            b0_addr = byte_row;
                            b1_addr = byte_row;
                            b0_wd   = r_item.byte_data;
                            b1_wd   = r_item.byte_data;
                            b0_en   = !r_item.byte_addr[0];
                            b0_we   = !r_item.byte_addr[0];
                            b1_en   = r_item.byte_addr[0];
                            b1_we   = r_item.byte_addr[0];
                        end
                        n_res.status = !byte_ok;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end
                    OP_READ: begin
                        if (byte_ok) begin
                            b0_addr = byte_row;
                            b1_addr = byte_row;
                            b0_en   = !r_item.byte_addr[0];
                            b1_en   = r_item.byte_addr[0];
                            n_state = S_DATA;
                        end else begin
                            n_res.status = 1'b1;
                            n_done       = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    OP_GET, OP_SET: begin
                        if (in_tab) begin
                            b0_en   = 1'b1;
                            b1_en   = 1'b1;
                            n_state = S_DATA;
                        end else begin
                            n_res.status = 1'b1;
                            n_done       = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    OP_FREE: begin
                        // The walk ends on a chain marker, a free or reserved entry, or
                        // a cluster past the table end (the last one is an error).
                        if (chain_live && in_tab) begin
                            b0_en   = 1'b1;
                            b1_en   = 1'b1;
                            n_state = S_DATA;
                        end else begin
                            n_res.freed_count = r_freed;
                            n_res.status      = chain_live;
                            n_done            = 1'b1;
                            n_state           = S_IDLE;
                        end
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_DATA: begin
                n_res = '0;
                unique case (r_item.opcode)
                    OP_READ: begin
                        n_res.byte_out = r_item.byte_addr[0] ? q1 : q0;
                        n_done         = 1'b1;
                        n_state        = S_IDLE;
                    end
                    OP_GET: begin
                        n_res.entry = cur_entry;
                        n_done      = 1'b1;
                        n_state     = S_IDLE;
                    end
                    OP_SET: begin
                        b0_en   = 1'b1;
                        b0_we   = 1'b1;
                        b1_en   = 1'b1;
                        b1_we   = 1'b1;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_FREE: begin
                        // Zero this link and follow it; the next read comes in the cycle after
                        // this write, so a chain that loops back sees the zero and stops.
                        b0_en   = 1'b1;
                        b0_we   = 1'b1;
                        b0_wd   = lo_b1 ? mrg_zero[15:8] : mrg_zero[7:0];
                        b1_en   = 1'b1;
                        b1_we   = 1'b1;
                        b1_wd   = lo_b1 ? mrg_zero[7:0] : mrg_zero[15:8];
                        n_freed = r_freed + 12'd1;
                        n_cur   = cur_entry;
                        n_state = S_ISSUE;
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_SCAN: begin
                // The table is only read here, so one read is issued each cycle while
                // the data of the previous cluster is checked.
                n_res = '0;
                priority if (r_chk_v && (chk_entry == FREE_ENTRY)) begin
                    n_res.entry = r_chk;
                    n_done      = 1'b1;
                    n_state     = S_IDLE;
                end else if (scan_live) begin
                    b0_en       = 1'b1;
                    b1_en       = 1'b1;
                    n_chk       = r_cur;
                    n_chk_v     = 1'b1;
                    n_chk_lo_b1 = lo_b1;
                    n_cur       = r_cur + 12'd1;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_chk_v <= 1'b0;
            r_limit <= LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_chk_v <= n_chk_v;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_cur       <= n_cur;
        r_chk       <= n_chk;
        r_chk_lo_b1 <= n_chk_lo_b1;
        r_freed     <= n_freed;
        r_res       <= n_res;
    end

    fct_ram #(
        .DEPTH (BANK_ROWS),
        .WIDTH (8)
    ) u_bank_even (
        .i_clk   (i_clk),
        .i_en    (b0_en),
        .i_we    (b0_we),
        .i_addr  (b0_addr),
        .i_wdata (b0_wd),
        .o_rdata (q0)
    );

    fct_ram #(
        .DEPTH (BANK_ROWS),
        .WIDTH (8)
    ) u_bank_odd (
        .i_clk   (i_clk),
        .i_en    (b1_en),
        .i_we    (b1_we),
        .i_addr  (b1_addr),
        .i_wdata (b1_wd),
        .o_rdata (q1)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not make the engine busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while the engine is still busy");

    a_find_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (r_item.opcode == OP_FIND) && (o_result.entry != FREE_ENTRY)
        |-> (o_result.entry >= FIRST_CLUSTER) && (o_result.entry < r_limit))
        else $error("free cluster found outside the search range");

    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (r_item.opcode == OP_READ)
        |-> o_result.status == (IDX_W'(r_item.byte_addr) >= IDX_W'(TABLE_BYTES)))
        else $error("read byte status does not match the address range");
`endif

endmodule

>>> bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fct_pkg::*;

    // The block defines no codes for opcodes 6 and 7; they must do nothing.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // Highest cluster whose byte pair still lies inside the table.
    localparam int LAST_CLUSTER = ((TABLE_BYTES - 1) * 2) / 3;

    // Highest cluster that a free-chain walk still follows.
    localparam int LAST_LINK = CHAIN_END - 1;

    // Field value that asks the stimulus helpers for a random value.
    localparam int ANY = -1;

    localparam int IDLE_PERCENT  = 15;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;

    // One entry of the stimulus queue: either a table operation or a limit write.
    typedef struct {
        logic        is_cfg;
        logic        calm;
        logic [11:0] limit;
        t_fct_in     item;
    } table_cmd_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    t_fct_in     i_item     = '0;
    logic        o_done;
    t_fct_out    o_result;
    logic        i_cfg_we   = 1'b0;
    logic [11:0] i_cfg_data = '0;

    // Our own copy of the allocation table and of the search limit.
    logic [7:0]  fat_mirror [TABLE_BYTES];
    logic [11:0] search_limit = LIMIT_RESET;

    table_cmd_t  table_cmds [$];
    t_fct_out    results_due [$];

    int beats_offered = 0;
    int beats_taken   = 0;
    int error_count   = 0;
    int quiet_cycles  = 0;
    int items_queued  = 0;
    logic calm_phase  = 1'b0;

    fat12_cluster_table_engine u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------

    // A cluster is usable only when both bytes of its pair are in the table.
    function automatic bit entry_fits(input int c);
        return c + c / 2 + 1 < TABLE_BYTES;
    endfunction

    // Even clusters own the low byte and the low nibble of the next byte;
    // odd clusters own the high nibble of the low byte and the next byte.
    function automatic logic [11:0] entry_peek(input int c);
        int idx;
        idx = c + c / 2;
        if (c % 2 == 1) begin
            return {fat_mirror[idx + 1], fat_mirror[idx][7:4]};
        end
        return {fat_mirror[idx + 1][3:0], fat_mirror[idx]};
    endfunction

    function automatic void entry_poke(input int c, input logic [11:0] v);
        int idx;
        idx = c + c / 2;
        if (c % 2 == 1) begin
            fat_mirror[idx]     = {v[3:0], fat_mirror[idx][3:0]};
            fat_mirror[idx + 1] = v[11:4];
        end else begin
            fat_mirror[idx]     = v[7:0];
            fat_mirror[idx + 1] = {fat_mirror[idx + 1][7:4], v[11:8]};
        end
    endfunction

    // Applies one operation to the mirror and returns the result the block
    // must report for it. Fields an operation does not produce stay zero.
    function automatic t_fct_out fat_predict(input t_fct_in cmd);
        t_fct_out    res;
        int          cur;
        logic [11:0] nxt;
        res = '0;
        case (cmd.opcode)
            OP_LOAD: begin
                if (cmd.byte_addr < TABLE_BYTES) fat_mirror[cmd.byte_addr] = cmd.byte_data;
                else res.status = 1'b1;
            end
            OP_READ: begin
                if (cmd.byte_addr < TABLE_BYTES) res.byte_out = fat_mirror[cmd.byte_addr];
                else res.status = 1'b1;
            end
            OP_GET: begin
                if (entry_fits(cmd.cluster)) res.entry = entry_peek(cmd.cluster);
                else res.status = 1'b1;
            end
            OP_SET: begin
                if (entry_fits(cmd.cluster)) entry_poke(cmd.cluster, cmd.value);
                else res.status = 1'b1;
            end
            OP_FIND: begin
                // The search never looks past the end of the table.
                for (int c = FIRST_CLUSTER; c < search_limit; c++) begin
                    if (!entry_fits(c)) break;
                    if (entry_peek(c) == FREE_ENTRY) begin
                        res.entry = c;
                        break;
                    end
                end
            end
            OP_FREE: begin
                // Zeroing as we go guarantees that a looping chain ends.
                cur = cmd.cluster;
                while (cur >= FIRST_CLUSTER && cur < CHAIN_END) begin
                    if (!entry_fits(cur)) begin
                        res.status = 1'b1;
                        break;
                    end
                    nxt = entry_peek(cur);
                    entry_poke(cur, FREE_ENTRY);
                    res.freed_count = res.freed_count + 1'b1;
                    cur = nxt;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: runs on the falling edge. A beat stays on the port until the
    // monitor has seen it accepted. Limit writes go out only once the
    // block has settled and been quiet with nothing outstanding.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic        nxt_start;
        logic        nxt_we;
        logic [11:0] nxt_limit;
        t_fct_in     nxt_item;
        table_cmd_t  head;
        nxt_start = 1'b0;
        nxt_we    = 1'b0;
        nxt_limit = i_cfg_data;
        nxt_item  = i_item;
        if (results_due.size() == 0 && !start && busy === 1'b0) quiet_cycles++;
        else quiet_cycles = 0;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if (start && beats_taken != beats_offered) begin
            // The current beat has not been taken yet; keep it up.
            nxt_start = 1'b1;
        end else if (table_cmds.size() != 0 && !i_cfg_we) begin
            head = table_cmds[0];
            if (head.is_cfg) begin
                if (quiet_cycles >= SETTLE_CYCLES) begin
                    nxt_we    = 1'b1;
                    nxt_limit = head.limit;
                    void'(table_cmds.pop_front());
                end
            end else if (head.calm || $urandom_range(99) >= IDLE_PERCENT) begin
                nxt_start = 1'b1;
                nxt_item  = head.item;
                void'(table_cmds.pop_front());
                beats_offered++;
            end
        end
        start      <= nxt_start;
        i_item     <= nxt_item;
        i_cfg_we   <= nxt_we;
        i_cfg_data <= nxt_limit;
    end

    // ------------------------------------------------------------------
    // Monitor: runs on the rising edge. A result beat is checked before a
    // newly accepted beat is predicted, so the queue order always matches
    // the order in which the block takes its work.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_fct_out want;
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (results_due.size() == 0) begin
                    $error("result beat with nothing outstanding: %p", o_result);
                    error_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("entry", want.entry, o_result.entry);
                    check_field("byte_out", want.byte_out, o_result.byte_out);
                    check_field("freed_count", want.freed_count, o_result.freed_count);
                    check_field("status", want.status, o_result.status);
                end
            end
            if (i_cfg_we) search_limit = i_cfg_data;
            if (start && busy === 1'b0) begin
                results_due.push_back(fat_predict(i_item));
                beats_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. A field given as ANY gets a random value, so the
    // fields an operation ignores still see every bit toggle.
    // ------------------------------------------------------------------
    task automatic queue_op(input logic [2:0] op, input int cl = ANY, input int val = ANY,
                            input int addr = ANY, input int data = ANY);
        table_cmd_t cmd;
        cmd.is_cfg = 1'b0;
        cmd.calm   = calm_phase;
        cmd.limit  = '0;
        cmd.item.opcode    = op;
        cmd.item.cluster   = (cl < 0) ? $urandom_range(4095) : cl;
        cmd.item.value     = (val < 0) ? $urandom_range(4095) : val;
        cmd.item.byte_addr = (addr < 0) ? $urandom_range(8191) : addr;
        cmd.item.byte_data = (data < 0) ? $urandom_range(255) : data;
        table_cmds.push_back(cmd);
        items_queued++;
    endtask

    task automatic queue_limit(input logic [11:0] lim);
        table_cmd_t cmd;
        cmd.is_cfg = 1'b1;
        cmd.calm   = 1'b0;
        cmd.limit  = lim;
        cmd.item   = '0;
        table_cmds.push_back(cmd);
    endtask

    // Builds a chain with set-entry beats and then frees it from its head.
    // About half of the links sit low in the table so that find-free hits them.
    // The tail is an end marker, a free or reserved value, a link back into the
    // chain, or a cluster past the table end.
    task automatic queue_chain();
        int          len;
        int          links [8];
        logic [11:0] tail;
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++) begin
            links[i] = $urandom_range(1) ? $urandom_range(63, FIRST_CLUSTER)
                                         : $urandom_range(LAST_CLUSTER, FIRST_CLUSTER);
        end
        for (int i = 0; i < len - 1; i++) queue_op(OP_SET, links[i], links[i + 1]);
        case ($urandom_range(3))
            0:       tail = $urandom_range(4095, CHAIN_END);
            1:       tail = $urandom_range(FIRST_CLUSTER - 1);
            2:       tail = links[$urandom_range(len - 1)];
            default: tail = $urandom_range(LAST_LINK, LAST_CLUSTER + 1);
        endcase
        queue_op(OP_SET, links[len - 1], tail);
        if ($urandom_range(1)) queue_op(OP_GET, links[0]);
        queue_op(OP_FREE, links[0]);
        if ($urandom_range(2) == 0) queue_op(OP_FIND);
    endtask

    // Addresses and clusters stay mostly inside the table; about one in ten
    // spans the whole field to hit the out-of-range paths.
    task automatic queue_random_op();
        int roll;
        int cl;
        int addr;
        roll = $urandom_range(99);
        cl   = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(LAST_CLUSTER);
        addr = ($urandom_range(9) == 0) ? $urandom_range(8191)
                                        : $urandom_range(TABLE_BYTES - 1);
        if (roll < 10)      queue_op(OP_LOAD, ANY, ANY, addr);
        else if (roll < 24) queue_op(OP_READ, ANY, ANY, addr);
        else if (roll < 38) queue_op(OP_GET, cl);
        else if (roll < 52) queue_op(OP_SET, cl, ($urandom_range(4) == 0) ? int'(FREE_ENTRY) : ANY);
        else if (roll < 62) queue_op(OP_FIND);
        else if (roll < 70) queue_op(OP_FREE, ($urandom_range(3) == 0) ? $urandom_range(4095) : cl);
        else if (roll < 97) queue_chain();
        else                queue_op($urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7);
    endtask

    task automatic queue_random_phase(input int count);
        int mark;
        mark = items_queued;
        while (items_queued - mark < count) queue_random_op();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        // The table holds nothing defined after reset, so every byte is
        // loaded before anything reads it.
        for (int a = 0; a < TABLE_BYTES; a++) queue_op(OP_LOAD, ANY, ANY, a);

        // Directed part, run with the reset value of the search limit.
        queue_op(OP_READ, ANY, ANY, 0);
        queue_op(OP_READ, ANY, ANY, TABLE_BYTES - 1);
        queue_op(OP_READ, ANY, ANY, TABLE_BYTES);
        queue_op(OP_READ, ANY, ANY, 8191);
        queue_op(OP_LOAD, ANY, ANY, 8191, 255);
        queue_op(OP_LOAD, ANY, ANY, TABLE_BYTES - 1, 0);
        queue_op(OP_GET, 0);
        queue_op(OP_GET, LAST_CLUSTER);
        queue_op(OP_GET, LAST_CLUSTER + 1);
        queue_op(OP_GET, 4095);
        queue_op(OP_SET, LAST_CLUSTER, 4095);
        queue_op(OP_SET, 4095, FREE_ENTRY);
        queue_op(OP_SET, FIRST_CLUSTER, FREE_ENTRY);
        queue_op(OP_SET, 3, 'hABC);
        queue_op(OP_GET, 3);
        queue_op(OP_FIND);
        // Chain starts that free nothing, and one that starts past the table.
        queue_op(OP_FREE, FIRST_CLUSTER - 1);
        queue_op(OP_FREE, CHAIN_END);
        queue_op(OP_FREE, LAST_LINK);
        // A two-link loop, then a chain that runs off the end of the table.
        queue_op(OP_SET, 10, 11);
        queue_op(OP_SET, 11, 10);
        queue_op(OP_FREE, 10);
        queue_op(OP_SET, 20, LAST_CLUSTER + 1);
        queue_op(OP_FREE, 20);
        queue_op(OP_SPARE_6);
        queue_op(OP_SPARE_7);

        // Random phases under several limits, the extremes among them.
        queue_limit(3);
        queue_random_phase(60);
        queue_limit(LAST_CLUSTER + 1);
        queue_random_phase(70);
        queue_limit($urandom_range(LAST_CLUSTER + 1, 3));
        queue_random_phase(70);
        // One long stretch where the driver never idles.
        calm_phase = 1'b1;
        queue_limit(LIMIT_RESET);
        queue_random_phase(80);
        calm_phase = 1'b0;
        queue_limit(40);
        queue_random_phase(60);
        queue_limit(LAST_CLUSTER + 1);
        queue_random_phase(60);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (table_cmds.size() != 0 || beats_taken != beats_offered
               || results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0 && results_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest correct run, in which every search
    // scans the whole table.
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
